// File: hw/rtl/tccc_pkg.sv
// Shared types and constants for the text console cursor control block.
`timescale 1ns / 1ps

package tccc_pkg;

    // Limits and reset values of the screen geometry
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_TAB_STOP    = 8;
    localparam int COLUMNS_RESET   = 80;
    localparam int ROWS_RESET      = 25;

    // Field widths
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int CFG_COL_W = 9;
    localparam int CFG_ROW_W = 8;
    localparam int TAB_CNT_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
    } char_beat_t;

    typedef struct packed {
        logic [COL_W-1:0] cell_column;
        logic [ROW_W-1:0] cell_row;
        logic [7:0]       glyph;
        logic [31:0]      draw_fg;
        logic [31:0]      draw_bg;
        logic             last_of_run;
    } cell_beat_t;

    // Effective (saturated) screen geometry
    typedef struct packed {
        logic [CFG_COL_W-1:0] columns;
        logic [CFG_ROW_W-1:0] rows;
    } geom_t;

    // Cursor update and write request from the step logic
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [COL_W-1:0]     cell_col;
        logic [ROW_W-1:0]     cell_row;
        logic [7:0]           glyph;
        logic [COL_W-1:0]     col_next;
        logic [ROW_W-1:0]     row_next;
        logic [TAB_CNT_W-1:0] tab_left_next;
        logic                 tab_busy_next;
    } step_t;

endpackage

// File: hw/rtl/tccc_cfg.sv
// Geometry registers of the text console, saturated on write.
`timescale 1ns / 1ps

module tccc_cfg #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tccc_pkg::geom_t                 geom
);
    import tccc_pkg::*;

    localparam int COLS_RST = (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET;
    localparam int ROWS_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

    logic [CFG_COL_W-1:0] columns_reg, columns_next;
    logic [CFG_ROW_W-1:0] rows_reg, rows_next;
    logic [CFG_COL_W-1:0] wr_cols;
    logic [CFG_ROW_W-1:0] wr_rows;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        wr_cols = cfg_wdata[CFG_COL_W-1:0];
        if (wr_cols == '0)
            wr_cols = CFG_COL_W'(1);
        else if (wr_cols > CFG_COL_W'(MAX_COLUMNS))
            wr_cols = CFG_COL_W'(MAX_COLUMNS);

        wr_rows = cfg_wdata[CFG_ROW_W-1:0];
        if (wr_rows == '0)
            wr_rows = CFG_ROW_W'(1);
        else if (wr_rows > CFG_ROW_W'(MAX_ROWS))
            wr_rows = CFG_ROW_W'(MAX_ROWS);

        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: columns_next = wr_cols;
                CFG_ROWS:    rows_next    = wr_rows;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= CFG_COL_W'(COLS_RST);
            rows_reg    <= CFG_ROW_W'(ROWS_RST);
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    assign geom.columns = columns_reg;
    assign geom.rows    = rows_reg;

endmodule

// File: hw/rtl/tccc_step.sv
// One cursor step: wrap, decode the character, pick the cell to write.
`timescale 1ns / 1ps

module tccc_step #(
    parameter int TAB_STOP = tccc_pkg::DEF_TAB_STOP
) (
    input  tccc_pkg::geom_t                geom,
    input  logic [tccc_pkg::COL_W-1:0]     cur_col,
    input  logic [tccc_pkg::ROW_W-1:0]     cur_row,
    input  logic [7:0]                     char_code,
    input  logic                           tab_active,
    input  logic [tccc_pkg::TAB_CNT_W-1:0] tab_left,
    output tccc_pkg::step_t                step
);
    import tccc_pkg::*;

    localparam int COL_CODES = 1 << COL_W;

    // Column modulo tab stop, built at elaboration
    logic [TAB_CNT_W-1:0] phase_tab [COL_CODES];

    for (genvar i = 0; i < COL_CODES; i++)
    begin : g_phase
        assign phase_tab[i] = TAB_CNT_W'(i % TAB_STOP);
    end

    always_comb
    begin
        logic [COL_W-1:0]     c0;
        logic [ROW_W-1:0]     r0;
        logic [ROW_W:0]       r_inc;
        logic [ROW_W:0]       r_pre;
        logic [COL_W:0]       c_inc;
        logic [TAB_CNT_W-1:0] left;
        logic [CFG_COL_W-1:0] last_col;
        logic [CFG_ROW_W-1:0] last_row;

        last_col = geom.columns - CFG_COL_W'(1);
        last_row = geom.rows - CFG_ROW_W'(1);

        // Pull a cursor left past a shrunk screen back inside it
        c0    = cur_col;
        r_pre = {1'b0, cur_row};
        if (!tab_active && ({1'b0, cur_col} >= geom.columns))
        begin
            c0    = '0;
            r_pre = {1'b0, cur_row} + (ROW_W+1)'(1);
        end
        r0 = (!tab_active && (r_pre >= geom.rows)) ? '0 : r_pre[ROW_W-1:0];

        r_inc = {1'b0, r0} + (ROW_W+1)'(1);
        c_inc = {1'b0, c0} + (COL_W+1)'(1);
        left  = tab_active ? tab_left : TAB_CNT_W'(TAB_STOP) - phase_tab[c0];

        step.emit          = 1'b1;
        step.last          = 1'b1;
        step.cell_col      = c0;
        step.cell_row      = r0;
        step.glyph         = char_code;
        step.tab_left_next = '0;
        step.tab_busy_next = 1'b0;

        // Advance one cell with the normal wrap
        if (c_inc >= geom.columns)
        begin
            step.col_next = '0;
            step.row_next = (r_inc >= geom.rows) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            step.col_next = c_inc[COL_W-1:0];
            step.row_next = r0;
        end

        if (tab_active || char_code == CH_TAB)
        begin
            step.glyph         = CH_SPACE;
            step.last          = (left == TAB_CNT_W'(1));
            step.tab_left_next = left - TAB_CNT_W'(1);
            step.tab_busy_next = (left != TAB_CNT_W'(1));
        end
        else if (char_code == CH_NEWLINE)
        begin
            step.emit     = 1'b0;
            step.col_next = '0;
            step.row_next = (r_inc >= geom.rows) ? '0 : r_inc[ROW_W-1:0];
        end
        else if (char_code == CH_BACKSPACE)
        begin
            step.glyph = CH_SPACE;
            if (c0 == '0)
            begin
                step.col_next = last_col[COL_W-1:0];
                step.row_next = (r0 == '0) ? last_row[ROW_W-1:0] : r0 - ROW_W'(1);
            end
            else
            begin
                step.col_next = c0 - COL_W'(1);
                step.row_next = r0;
            end
            step.cell_col = step.col_next;
            step.cell_row = step.row_next;
        end
    end

endmodule

// File: hw/rtl/tccc_out_reg.sv
// Result register of the cell write channel.
`timescale 1ns / 1ps

module tccc_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tccc_pkg::cell_beat_t load_data,
    output logic                 space,
    output logic                 cell_valid,
    input  logic                 cell_stall,
    output tccc_pkg::cell_beat_t cell_data
);
    import tccc_pkg::*;

    logic       valid_reg, valid_next;
    cell_beat_t data_reg;

    // Free when empty or when the waiting beat leaves this cycle
    assign space      = !valid_reg || !cell_stall;
    assign valid_next = space ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (space && load)
            data_reg <= load_data;
    end

    assign cell_valid = valid_reg;
    assign cell_data  = data_reg;

endmodule

// File: hw/rtl/text_console_cursor_control.sv
// Top level of the text console cursor control block.
//
// Takes one formatted character beat per cycle when not stalled on the
// char channel (char_valid / char_stall, payload char_data) and emits
// character-cell write beats on the cell channel (cell_valid /
// cell_stall, cell_data) for a glyph renderer. Screen geometry comes in
// on the cfg channel: index 0 sets the column count, index 1 the row count;
// cfg_ready is always high and values are saturated to the supported range.
//
// An accepted character's first cell beat appears in the following cycle.
// Printable characters and backspace write one cell each, newline emits
// nothing. A tab emits one space per cycle while the receiver does not
// stall, from one to TAB_STOP beats, and holds char_stall high until its
// last beat is formed; that run length is what sets the rate for tabs.
//
// Reset clears the cursor to the top left cell, empties the result
// register and restores 80 columns by 25 rows. When the receiver stalls,
// the waiting cell beat holds and char_stall rises for everything but a
// newline, which only moves the cursor and is still taken.
`timescale 1ns / 1ps

module text_console_cursor_control #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS,
    parameter int TAB_STOP    = tccc_pkg::DEF_TAB_STOP
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    output logic                            char_stall,
    input  tccc_pkg::char_beat_t            char_data,
    output logic                            cell_valid,
    input  logic                            cell_stall,
    output tccc_pkg::cell_beat_t            cell_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tccc_pkg::*;

    geom_t      geom;
    step_t      step;
    cell_beat_t cell_next;

    // Cursor and tab run state
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 tab_busy_reg, tab_busy_next;
    logic [TAB_CNT_W-1:0] tab_left_reg, tab_left_next;
    logic [31:0]          hold_fg_reg, hold_bg_reg;

    logic       space;
    logic       fire;
    logic [7:0] src_char;
    logic [31:0] src_fg;
    logic [31:0] src_bg;

    tccc_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    // During a tab run the held colors drive the step; otherwise the beat
    always_comb
    begin
        src_char = tab_busy_reg ? CH_TAB : char_data.char_code;
        src_fg   = tab_busy_reg ? hold_fg_reg : char_data.fg_color;
        src_bg   = tab_busy_reg ? hold_bg_reg : char_data.bg_color;
    end

    tccc_step #(
        .TAB_STOP (TAB_STOP)
    ) u_step (
        .geom       (geom),
        .cur_col    (col_reg),
        .cur_row    (row_reg),
        .char_code  (src_char),
        .tab_active (tab_busy_reg),
        .tab_left   (tab_left_reg),
        .step       (step)
    );

    // Stall input while a tab run owns the step logic, or while the result
    // register is full; a newline needs no result slot
    assign char_stall = tab_busy_reg ||
                        (!space && (char_data.char_code != CH_NEWLINE));

    // A step runs for an accepted beat or for the next space of a tab run
    assign fire = tab_busy_reg ? space : (char_valid && !char_stall);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        tab_busy_next = tab_busy_reg;
        tab_left_next = tab_left_reg;
        if (fire)
        begin
            col_next      = step.col_next;
            row_next      = step.row_next;
            tab_busy_next = step.tab_busy_next;
            tab_left_next = step.tab_left_next;
        end

        cell_next.cell_column = step.cell_col;
        cell_next.cell_row    = step.cell_row;
        cell_next.glyph       = step.glyph;
        cell_next.draw_fg     = src_fg;
        cell_next.draw_bg     = src_bg;
        cell_next.last_of_run = step.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            tab_busy_reg <= 1'b0;
            tab_left_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            tab_busy_reg <= tab_busy_next;
            tab_left_reg <= tab_left_next;
        end
    end

    // Capture the colors of every accepted beat; a tab run drives them
    always_ff @(posedge clk)
    begin
        if (fire && !tab_busy_reg)
        begin
            hold_fg_reg <= char_data.fg_color;
            hold_bg_reg <= char_data.bg_color;
        end
    end

    tccc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && step.emit),
        .load_data  (cell_next),
        .space      (space),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_data  (cell_data)
    );

endmodule

// File: tb/text_console_cursor_control_tb.sv
// Self-checking testbench for the text console cursor control block.
`timescale 1ns / 1ps

module text_console_cursor_control_tb;
    import tccc_pkg::*;

    // Clock, reset and block ports
    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    char_beat_t char_data;
    logic       cell_valid;
    logic       cell_stall;
    cell_beat_t cell_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predicted cursor and geometry registers (raw, as written)
    int                   cur_col;
    int                   cur_row;
    logic [CFG_COL_W-1:0] geo_columns;
    logic [CFG_ROW_W-1:0] geo_rows;

    // Cell writes still owed by the block, oldest first
    cell_beat_t cell_expect_q[$];

    // Scoreboard counters
    int mismatches;
    int unexpected_cells;
    int cells_checked;
    int chars_sent;
    int geometry_writes;

    // Sender burst control and receiver stall pattern
    bit send_idle_on;
    int burst_left;
    bit rcv_stall_on;
    bit stall_state;
    int stall_left;

    text_console_cursor_control dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_data  (cell_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time: far beyond the slowest legal run
    // (every character a tab with eight beats, each beat stalled).
    initial
    begin
        #3_000_000;
        $display("Timeout waiting for the block to finish");
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Wrap the cursor onto the next row and the row back to the top.
    function void wrap_cursor(input int cols, input int nrows);
        if (cur_col >= cols)
        begin
            cur_col = 0;
            cur_row = cur_row + 1;
        end
        if (cur_row >= nrows)
            cur_row = 0;
    endfunction

    function automatic cell_beat_t make_cell(input logic [7:0] g, input char_beat_t beat);
        cell_beat_t c;
        c.cell_column = cur_col[COL_W-1:0];
        c.cell_row    = cur_row[ROW_W-1:0];
        c.glyph       = g;
        c.draw_fg     = beat.fg_color;
        c.draw_bg     = beat.bg_color;
        c.last_of_run = 1'b0;
        return c;
    endfunction

    // Advance the cursor model by one character and queue the cell
    // writes it should cause.
    task automatic predict_cells(input char_beat_t beat);
        int         cols;
        int         nrows;
        int         n_space;
        cell_beat_t run[$];

        // Registers out of range act saturated; zero acts as one
        cols  = (geo_columns == 0) ? 1 : int'(geo_columns);
        if (cols > DEF_MAX_COLUMNS)
            cols = DEF_MAX_COLUMNS;
        nrows = (geo_rows == 0) ? 1 : int'(geo_rows);
        if (nrows > DEF_MAX_ROWS)
            nrows = DEF_MAX_ROWS;

        // A cursor left outside a shrunk screen is pulled back first
        wrap_cursor(cols, nrows);

        if (beat.char_code == CH_NEWLINE)
        begin
            cur_col = 0;
            cur_row = cur_row + 1;
            wrap_cursor(cols, nrows);
        end
        else if (beat.char_code == CH_BACKSPACE)
        begin
            if (cur_col == 0)
            begin
                cur_col = cols - 1;
                cur_row = (cur_row == 0) ? nrows - 1 : cur_row - 1;
            end
            else
                cur_col = cur_col - 1;
            run.push_back(make_cell(CH_SPACE, beat));
            wrap_cursor(cols, nrows);
        end
        else if (beat.char_code == CH_TAB)
        begin
            n_space = DEF_TAB_STOP - (cur_col % DEF_TAB_STOP);
            repeat (n_space)
            begin
                run.push_back(make_cell(CH_SPACE, beat));
                cur_col = cur_col + 1;
                wrap_cursor(cols, nrows);
            end
        end
        else
        begin
            run.push_back(make_cell(beat.char_code, beat));
            cur_col = cur_col + 1;
            wrap_cursor(cols, nrows);
        end

        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i])
            cell_expect_q.push_back(run[i]);
    endtask

    // ------------------------------------------------------------------
    // Cell channel: receiver stall pattern and checker
    // ------------------------------------------------------------------

    // Stall in runs of random length; hold low when stalls are off.
    always @(negedge clk)
    begin
        if (!rcv_stall_on)
            cell_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_state = !stall_state;
                stall_left  = stall_state ? $urandom_range(1, 6) : $urandom_range(0, 9);
            end
            else
                stall_left = stall_left - 1;
            cell_stall <= stall_state;
        end
    end

    // Compare every accepted cell beat with the oldest prediction.
    always @(posedge clk)
    begin
        cell_beat_t want;
        if (rst_n && cell_valid && !cell_stall)
        begin
            if (cell_expect_q.size() == 0)
            begin
                unexpected_cells = unexpected_cells + 1;
                if (mismatches + unexpected_cells <= 10)
                    $display("Unexpected cell beat col=%0d row=%0d glyph=%0d",
                             cell_data.cell_column, cell_data.cell_row, cell_data.glyph);
            end
            else
            begin
                want = cell_expect_q.pop_front();
                cells_checked = cells_checked + 1;
                if (cell_data.cell_column !== want.cell_column ||
                    cell_data.cell_row    !== want.cell_row    ||
                    cell_data.glyph       !== want.glyph       ||
                    cell_data.draw_fg     !== want.draw_fg     ||
                    cell_data.draw_bg     !== want.draw_bg     ||
                    cell_data.last_of_run !== want.last_of_run)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches + unexpected_cells <= 10)
                    begin
                        $display("Cell mismatch: expected col=%0d row=%0d glyph=%0d fg=%h bg=%h last=%b",
                                 want.cell_column, want.cell_row, want.glyph,
                                 want.draw_fg, want.draw_bg, want.last_of_run);
                        $display("               actual   col=%0d row=%0d glyph=%0d fg=%h bg=%h last=%b",
                                 cell_data.cell_column, cell_data.cell_row, cell_data.glyph,
                                 cell_data.draw_fg, cell_data.draw_bg, cell_data.last_of_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Char channel and configuration port
    // ------------------------------------------------------------------

    // Offer one character beat, hold it until taken, then maybe pause.
    task automatic send_char(input logic [7:0] code, input logic [31:0] fg,
                             input logic [31:0] bg);
        char_beat_t beat;
        int         gap;
        beat.char_code = code;
        beat.fg_color  = fg;
        beat.bg_color  = bg;
        @(negedge clk);
        char_valid <= 1'b1;
        char_data  <= beat;
        do
            @(posedge clk);
        while (char_stall);
        predict_cells(beat);
        chars_sent = chars_sent + 1;

        // End of a burst: drop valid for a random gap
        if (send_idle_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 5);
                @(negedge clk);
                char_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(0, 7);
            end
            else
                burst_left = burst_left - 1;
        end
    endtask

    // Stop sending and wait until every predicted cell beat has come;
    // the extra cycles cover a trailing newline that writes nothing.
    task automatic drain_cells();
        @(negedge clk);
        char_valid <= 1'b0;
        while (cell_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one geometry register while the block is idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain_cells();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_COLUMNS)
            geo_columns = value;
        else if (idx == CFG_ROWS)
            geo_rows = value[CFG_ROW_W-1:0];
        geometry_writes = geometry_writes + 1;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] columns,
                                input logic [CFG_DATA_W-1:0] rows);
        cfg_write(CFG_COLUMNS, columns);
        cfg_write(CFG_ROWS, rows);
    endtask

    // Pick a character: mostly printable text, a fair share of control
    // codes, and now and then any byte at all.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return CH_NEWLINE;
        else if (r < 24)
            return CH_TAB;
        else if (r < 36)
            return CH_BACKSPACE;
        else if (r < 86)
            return 8'($urandom_range(33, 126));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default 80 x 25 screen: control codes, field extremes and the
    // wrap of backspace over the top left corner.
    task automatic test_control_codes();
        send_char(CH_BACKSPACE, 32'hFFFF_FFFF, 32'h0000_0000); // (0,0) -> last cell
        send_char(8'hFF,        32'h0000_0000, 32'hFFFF_FFFF); // wraps to (0,0)
        send_char(8'h00,        32'hAAAA_AAAA, 32'h5555_5555);
        send_char(CH_NEWLINE,   32'h5555_5555, 32'hAAAA_AAAA); // writes nothing
        send_char(CH_BACKSPACE, 32'h1234_5678, 32'h9ABC_DEF0); // row above, last column
        send_char(CH_TAB,       32'h0F0F_0F0F, 32'hF0F0_F0F0); // one space, then wrap
        send_char(CH_TAB,       32'hDEAD_BEEF, 32'h0000_0001); // full eight spaces
        send_char("A",          32'h8000_0000, 32'h7FFF_FFFF);
        send_char(CH_TAB,       32'h0000_00FF, 32'hFF00_0000); // seven spaces
        send_char(CH_BACKSPACE, 32'h0101_0101, 32'h8080_8080); // mid row
    endtask

    // Zero in both registers acts as a one-cell screen; the cursor left
    // far out on the default screen is pulled back to the only cell.
    task automatic test_tiny_screen();
        set_geometry(9'd0, 9'd0);
        send_char("B",          $urandom, $urandom);
        send_char(CH_TAB,       $urandom, $urandom); // eight spaces, all on one cell
        send_char(CH_BACKSPACE, $urandom, $urandom);
        send_char(CH_NEWLINE,   $urandom, $urandom);
    endtask

    // Largest screen, reached with register values past the limits.
    task automatic test_full_screen();
        set_geometry(9'h1FF, 9'h1FF);
        send_char(CH_BACKSPACE, $urandom, $urandom); // to column 255, row 127
        send_char("Z",          $urandom, $urandom); // wraps row to the top
        send_char(CH_BACKSPACE, $urandom, $urandom);
        send_char(CH_TAB,       $urandom, $urandom); // single space at column 255
        set_geometry(9'd256, 9'd128);
        send_char(CH_BACKSPACE, $urandom, $urandom);
    endtask

    // Shrink the screen under a cursor at its far corner, then run tabs
    // that spill over onto the next row.
    task automatic test_shrunk_screen();
        set_geometry(9'd9, 9'd3);
        send_char("Q",    $urandom, $urandom);
        send_char(CH_TAB, $urandom, $urandom);
        send_char(CH_TAB, $urandom, $urandom);
    endtask

    // Random text over several geometries; the first phase runs with no
    // idling on either side, later ones with bursts and stalls. Halfway
    // through each phase, hold the sender until all writes are out.
    task automatic test_random_text();
        logic [CFG_DATA_W-1:0] col_set[4] = '{9'd80, 9'd12, 9'd300, 9'd5};
        logic [CFG_DATA_W-1:0] row_set[4] = '{9'd25, 9'd3,  9'd200, 9'd1};
        for (int p = 0; p < 4; p++)
        begin
            set_geometry(col_set[p], row_set[p]);
            send_idle_on = (p != 0);
            rcv_stall_on = (p != 0);
            for (int i = 0; i < 30; i++)
            begin
                send_char(pick_char(), $urandom, $urandom);
                if (i == 14)
                    drain_cells();
            end
        end
        send_idle_on = 1'b1;
        rcv_stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        char_valid      = 1'b0;
        char_data       = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_COLUMNS;
        cfg_wdata       = '0;
        cur_col         = 0;
        cur_row         = 0;
        geo_columns     = CFG_COL_W'(COLUMNS_RESET);
        geo_rows        = CFG_ROW_W'(ROWS_RESET);
        mismatches      = 0;
        unexpected_cells = 0;
        cells_checked   = 0;
        chars_sent      = 0;
        geometry_writes = 0;
        send_idle_on    = 1'b1;
        burst_left      = 0;
        rcv_stall_on    = 1'b1;
        stall_state     = 1'b0;
        stall_left      = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_control_codes();
        test_tiny_screen();
        test_full_screen();
        test_shrunk_screen();
        test_random_text();

        // Flush and let the result register settle before judging
        drain_cells();
        repeat (8) @(posedge clk);

        if (cell_expect_q.size() != 0)
            $display("%0d predicted cell beats never arrived", cell_expect_q.size());
        $display("Ran %0d characters through %0d geometry writes; checked %0d cell beats.",
                 chars_sent, geometry_writes, cells_checked);
        $display("Mismatched beats: %0d, unexpected beats: %0d",
                 mismatches, unexpected_cells);

        if (mismatches == 0 && unexpected_cells == 0 && cell_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
